[hdl/i2cmbe_pkg.sv]
//------------------------------------------------------------------------------
// I2C master bit engine package
// Request codes, sequencer command encoding and the queue entry type.
//------------------------------------------------------------------------------
`default_nettype none

package i2cmbe_pkg;

   // request codes on req_type
   localparam logic [2:0] REQ_TICK   = 3'd0;
   localparam logic [2:0] REQ_START  = 3'd1;
   localparam logic [2:0] REQ_STOP   = 3'd2;
   localparam logic [2:0] REQ_WRITE  = 3'd3;
   localparam logic [2:0] REQ_READ   = 3'd4;
   localparam logic [2:0] REQ_SACK   = 3'd5;
   localparam logic [2:0] REQ_RACK   = 3'd6;
   localparam logic [2:0] REQ_UNUSED = 3'd7;

   localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;
   localparam logic [4:0] WRITE_LAST_PH   = 5'd23;
   localparam logic [4:0] READ_LAST_PH    = 5'd16;

   // queue between the front and the sequencer
   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // sequencer command, one-hot; CMD_IDLE in a queue entry marks a tick
   typedef enum logic [6:0] {
      CMD_IDLE  = 7'b0000001,
      CMD_START = 7'b0000010,
      CMD_STOP  = 7'b0000100,
      CMD_WRITE = 7'b0001000,
      CMD_READ  = 7'b0010000,
      CMD_SACK  = 7'b0100000,
      CMD_RACK  = 7'b1000000
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;      // command to load, or CMD_IDLE for a tick
      logic [7:0] tx_load;  // shift value for write byte / send ack
      logic       sda_in;   // sampled SDA level for a tick
   } entry_type;

endpackage

`default_nettype wire

[hdl/i2cmbe_front.sv]
//------------------------------------------------------------------------------
// I2C master bit engine front end
// Classifies request items and holds them in a short queue for the sequencer.
//------------------------------------------------------------------------------
`default_nettype none

module i2cmbe_front
   import i2cmbe_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_type,
   input  wire logic [7:0]  req_tx_byte,
   input  wire logic        req_ack_bit,
   input  wire logic        req_sda_in,
   output logic             q_valid,
   output entry_type        q_entry,
   input  wire logic        q_pop
);

   entry_type           queue_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   entry_type           new_entry;
   logic                push;

   always_comb begin
      new_entry.sda_in  = req_sda_in;
      new_entry.tx_load = 8'd0;
      case (req_type)
         REQ_START: new_entry.cmd = CMD_START;
         REQ_STOP:  new_entry.cmd = CMD_STOP;
         REQ_WRITE: begin
            new_entry.cmd     = CMD_WRITE;
            new_entry.tx_load = req_tx_byte;
         end
         REQ_READ:  new_entry.cmd = CMD_READ;
         REQ_SACK:  begin
            new_entry.cmd     = CMD_SACK;
            new_entry.tx_load = {req_ack_bit, 7'd0};
         end
         REQ_RACK:  new_entry.cmd = CMD_RACK;
         default:   new_entry.cmd = CMD_IDLE;  // tick and the unused code
      endcase
   end

   assign req_stall = (count_ff == QCNT_W'(QDEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_entry   = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + QCNT_W'(push) - QCNT_W'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

`default_nettype wire

[hdl/i2cmbe_back.sv]
//------------------------------------------------------------------------------
// I2C master bit engine sequencer
// Runs the pin phase sequences one queue entry at a time and registers results.
//------------------------------------------------------------------------------
`default_nettype none

module i2cmbe_back
   import i2cmbe_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_valid,
   input  wire entry_type   q_entry,
   output logic             q_pop,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_scl_out,
   output logic             rsp_sda_out,
   output logic             rsp_busy_res,
   output logic             rsp_done_res,
   output logic [7:0]       rsp_rx_byte,
   output logic             rsp_ack_failed
);

   cmd_type     cmd_ff, cmd_in;
   logic [4:0]  phase_ff, phase_in;
   logic [1:0]  wsub_ff, wsub_in;
   logic [7:0]  tx_ff, tx_in;
   logic [7:0]  rx_ff, rx_in;
   logic [7:0]  poll_ff, poll_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   logic        nack_ff, nack_in;
   logic [7:0]  timeout_ff;
   logic        fin, hold, jump;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_done_ff;

   assign csr_ready = 1'b1;
   assign q_pop     = q_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      cmd_in   = cmd_ff;
      phase_in = phase_ff;
      wsub_in  = wsub_ff;
      tx_in    = tx_ff;
      rx_in    = rx_ff;
      poll_in  = poll_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      nack_in  = nack_ff;
      fin      = 1'b0;
      hold     = 1'b0;
      jump     = 1'b0;

      if (cmd_ff == CMD_IDLE) begin
         if (q_entry.cmd != CMD_IDLE) begin
            cmd_in   = q_entry.cmd;
            phase_in = 5'd0;
            wsub_in  = 2'd0;
            poll_in  = 8'd0;
            nack_in  = 1'b0;
            if (q_entry.cmd == CMD_WRITE || q_entry.cmd == CMD_SACK) begin
               tx_in = q_entry.tx_load;
            end
            if (q_entry.cmd == CMD_READ) begin
               rx_in = 8'd0;
            end
         end
      end else if (q_entry.cmd == CMD_IDLE) begin
         case (cmd_ff)
            CMD_START: begin
               if (phase_ff == 5'd0) sda_in = 1'b1;
               else if (phase_ff == 5'd1) scl_in = 1'b1;
               else if (phase_ff == 5'd2) sda_in = 1'b0;
               else begin
                  scl_in = 1'b0;
                  fin    = 1'b1;
               end
            end
            CMD_STOP: begin
               if (phase_ff == 5'd0) sda_in = 1'b0;
               else if (phase_ff == 5'd1) scl_in = 1'b1;
               else begin
                  sda_in = 1'b1;
                  fin    = 1'b1;
               end
            end
            CMD_WRITE: begin
               // wsub tracks the phase within one bit
               wsub_in = (wsub_ff == 2'd2) ? 2'd0 : wsub_ff + 2'd1;
               if (wsub_ff == 2'd0) sda_in = tx_ff[7];
               else if (wsub_ff == 2'd1) scl_in = 1'b1;
               else begin
                  scl_in = 1'b0;
                  tx_in  = {tx_ff[6:0], 1'b0};
                  fin    = (phase_ff >= WRITE_LAST_PH);
               end
            end
            CMD_READ: begin
               if (phase_ff == 5'd0) sda_in = 1'b1;
               else if (phase_ff[0]) begin
                  scl_in = 1'b1;
                  rx_in  = {rx_ff[6:0], q_entry.sda_in};
               end else begin
                  scl_in = 1'b0;
                  fin    = (phase_ff >= READ_LAST_PH);
               end
            end
            CMD_SACK: begin
               if (phase_ff == 5'd0) sda_in = tx_ff[7];
               else if (phase_ff == 5'd1) scl_in = 1'b1;
               else begin
                  scl_in = 1'b0;
                  fin    = 1'b1;
               end
            end
            CMD_RACK: begin
               if (phase_ff == 5'd0) sda_in = 1'b1;
               else if (phase_ff == 5'd1) begin
                  scl_in = 1'b1;
                  if (q_entry.sda_in) begin
                     if (poll_ff >= timeout_ff) begin
                        // timed out: flag nack and run a stop with SCL high
                        nack_in  = 1'b1;
                        cmd_in   = CMD_STOP;
                        phase_in = 5'd0;
                        jump     = 1'b1;
                     end else begin
                        poll_in = poll_ff + 8'd1;
                        hold    = 1'b1;
                     end
                  end
               end else begin
                  scl_in = 1'b0;
                  fin    = 1'b1;
               end
            end
            default: fin = 1'b1;
         endcase

         if (fin) begin
            cmd_in   = CMD_IDLE;
            phase_in = 5'd0;
         end else if (!hold && !jump) begin
            phase_in = phase_ff + 5'd1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (q_pop) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff       <= CMD_IDLE;
         phase_ff     <= 5'd0;
         wsub_ff      <= 2'd0;
         tx_ff        <= 8'd0;
         rx_ff        <= 8'd0;
         poll_ff      <= 8'd0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         nack_ff      <= 1'b0;
         timeout_ff   <= ACK_TIMEOUT_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            timeout_ff <= csr_data;
         end
         if (q_pop) begin
            cmd_ff   <= cmd_in;
            phase_ff <= phase_in;
            wsub_ff  <= wsub_in;
            tx_ff    <= tx_in;
            rx_ff    <= rx_in;
            poll_ff  <= poll_in;
            scl_ff   <= scl_in;
            sda_ff   <= sda_in;
            nack_ff  <= nack_in;
         end
      end
   end

   // result register: pins and status after the update
   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_done_ff <= fin;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_scl_out    = scl_ff;
   assign rsp_sda_out    = sda_ff;
   assign rsp_busy_res   = (cmd_ff != CMD_IDLE);
   assign rsp_done_res   = rsp_done_ff;
   assign rsp_rx_byte    = rx_ff;
   assign rsp_ack_failed = nack_ff;

endmodule

`default_nettype wire

[hdl/i2c_master_bit_engine_top.sv]
//------------------------------------------------------------------------------
// I2C master bit engine
// Command front end, item queue and pin phase sequencer.
//------------------------------------------------------------------------------
// Every request item yields exactly one result item. An item is taken each
// cycle unless req_stall is high: the front end decodes it into a two-entry
// queue, and the sequencer consumes one queue entry per cycle unless rsp_stall
// holds the result register, updating the SCL/SDA state, which also serves as
// the result register, at the edge where the entry leaves the queue.
// req_stall rises only when the queue is full, which
// happens only while rsp_stall holds the result register. The result fields
// are the pin and status state after the item: a command item loads the
// sequence without moving a pin, and each later tick item moves one phase.
// Write ack_timeout through the csr_ port only while no transfer is pending.
//------------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_engine_top
   import i2cmbe_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_type,
   input  wire logic [7:0]  req_tx_byte,
   input  wire logic        req_ack_bit,
   input  wire logic        req_sda_in,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_scl_out,
   output logic             rsp_sda_out,
   output logic             rsp_busy_res,
   output logic             rsp_done_res,
   output logic [7:0]       rsp_rx_byte,
   output logic             rsp_ack_failed
);

   logic       q_valid;
   logic       q_pop;
   entry_type  q_entry;

   i2cmbe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_type    (req_type),
      .req_tx_byte (req_tx_byte),
      .req_ack_bit (req_ack_bit),
      .req_sda_in  (req_sda_in),
      .q_valid     (q_valid),
      .q_entry     (q_entry),
      .q_pop       (q_pop)
   );

   i2cmbe_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_entry        (q_entry),
      .q_pop          (q_pop),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_scl_out    (rsp_scl_out),
      .rsp_sda_out    (rsp_sda_out),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_rx_byte    (rsp_rx_byte),
      .rsp_ack_failed (rsp_ack_failed)
   );

endmodule

`default_nettype wire

[test/i2c_master_bit_engine_top_test.sv]
//------------------------------------------------------------------------------
// I2C master bit engine testbench
// Drives command and tick items with random gaps on both channels, predicts
// the pin levels and status of every result, and checks each result in order.
// The ack timeout register is swept through several values between phases.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps

module i2c_master_bit_engine_top_test;
   import i2cmbe_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 1200;
   localparam int PHASES       = 6;

   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       busy;
      logic       done;
      logic [7:0] rx;
      logic       nack;
   } pin_result_type;

   // Pin sequencer prediction and in-order result checking.
   class bit_engine_scoreboard;
      logic [7:0]  ack_limit;
      logic [2:0]  seq_cmd;   // REQ_TICK while idle
      logic [4:0]  phase;
      logic [7:0]  tx_shift;
      logic [7:0]  rx_shift;
      logic [7:0]  polls;
      logic        scl;
      logic        sda;
      logic        nack;
      pin_result_type expected_pins[$];
      int          errors;
      int          results;
      int          completed;
      int          timeouts;

      function new();
         ack_limit = ACK_TIMEOUT_RST;
         seq_cmd   = REQ_TICK;
         phase     = '0;
         tx_shift  = '0;
         rx_shift  = '0;
         polls     = '0;
         scl       = 1'b1;
         sda       = 1'b1;
         nack      = 1'b0;
         errors    = 0;
         results   = 0;
         completed = 0;
         timeouts  = 0;
      endfunction

      task report(string msg);
         $display("MISMATCH: %s", msg);
         errors++;
      endtask

      function bit busy();
         return seq_cmd != REQ_TICK;
      endfunction

      function int pending();
         return expected_pins.size();
      endfunction

      // Move one pin phase; return 1 when the command completes.
      function bit advance_phase(logic sda_in);
         bit fin;
         bit hold;
         fin  = 1'b0;
         hold = 1'b0;
         case (seq_cmd)
            REQ_START: begin
               if (phase == 0) sda = 1'b1;
               else if (phase == 1) scl = 1'b1;
               else if (phase == 2) sda = 1'b0;
               else begin
                  scl = 1'b0;
                  fin = 1'b1;
               end
            end
            REQ_STOP: begin
               if (phase == 0) sda = 1'b0;
               else if (phase == 1) scl = 1'b1;
               else begin
                  sda = 1'b1;
                  fin = 1'b1;
               end
            end
            REQ_WRITE: begin
               case (phase % 3)
                  0: sda = tx_shift[7];
                  1: scl = 1'b1;
                  default: begin
                     scl      = 1'b0;
                     tx_shift = tx_shift << 1;
                     if (phase >= WRITE_LAST_PH) fin = 1'b1;
                  end
               endcase
            end
            REQ_READ: begin
               if (phase == 0) sda = 1'b1;
               else if (phase[0]) begin
                  scl      = 1'b1;
                  rx_shift = {rx_shift[6:0], sda_in};
               end else begin
                  scl = 1'b0;
                  if (phase >= READ_LAST_PH) fin = 1'b1;
               end
            end
            REQ_SACK: begin
               if (phase == 0) sda = tx_shift[7];
               else if (phase == 1) scl = 1'b1;
               else begin
                  scl = 1'b0;
                  fin = 1'b1;
               end
            end
            REQ_RACK: begin
               if (phase == 0) sda = 1'b1;
               else if (phase == 1) begin
                  scl = 1'b1;
                  if (sda_in) begin
                     // out of polls: flag nack and fall into a stop with SCL high
                     if (polls >= ack_limit) begin
                        nack    = 1'b1;
                        seq_cmd = REQ_STOP;
                        phase   = '0;
                        return 1'b0;
                     end
                     polls++;
                     hold = 1'b1;
                  end
               end else begin
                  scl = 1'b0;
                  fin = 1'b1;
               end
            end
            default: fin = 1'b1;
         endcase
         if (!fin && !hold) phase++;
         return fin;
      endfunction

      // Predict the result of an accepted item; return 1 unless it was ignored.
      function bit note_request(logic [2:0] kind, logic [7:0] tx_byte, logic ack_bit,
                                logic sda_in);
         pin_result_type want;
         bit          fin;
         bit          moved;
         fin   = 1'b0;
         moved = 1'b0;
         if (seq_cmd == REQ_TICK) begin
            if (kind >= REQ_START && kind <= REQ_RACK) begin
               moved   = 1'b1;
               seq_cmd = kind;
               phase   = '0;
               polls   = '0;
               nack    = 1'b0;
               if (kind == REQ_WRITE) tx_shift = tx_byte;
               else if (kind == REQ_SACK) tx_shift = {ack_bit, 7'b0};
               if (kind == REQ_READ) rx_shift = '0;
            end
         end else if (kind == REQ_TICK || kind == REQ_UNUSED) begin
            moved = 1'b1;
            fin   = advance_phase(sda_in);
            if (fin) begin
               seq_cmd = REQ_TICK;
               phase   = '0;
            end
         end
         want.scl  = scl;
         want.sda  = sda;
         want.busy = busy();
         want.done = fin;
         want.rx   = rx_shift;
         want.nack = nack;
         expected_pins.push_back(want);
         return moved;
      endfunction

      task check_response(pin_result_type got);
         pin_result_type want;
         if (expected_pins.size() == 0) begin
            report("result transfer with no result expected");
            return;
         end
         want = expected_pins.pop_front();
         results++;
         if (want.done) completed++;
         if (want.done && want.nack) timeouts++;
         if (got.scl !== want.scl)
            report($sformatf("result %0d scl_out %b, expected %b", results, got.scl, want.scl));
         if (got.sda !== want.sda)
            report($sformatf("result %0d sda_out %b, expected %b", results, got.sda, want.sda));
         if (got.busy !== want.busy)
            report($sformatf("result %0d busy_res %b, expected %b", results, got.busy,
                             want.busy));
         if (got.done !== want.done)
            report($sformatf("result %0d done_res %b, expected %b", results, got.done,
                             want.done));
         if (got.rx !== want.rx)
            report($sformatf("result %0d rx_byte %h, expected %h", results, got.rx, want.rx));
         if (got.nack !== want.nack)
            report($sformatf("result %0d ack_failed %b, expected %b", results, got.nack,
                             want.nack));
      endtask
   endclass

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic [2:0] req_type       = REQ_TICK;
   logic [7:0] req_tx_byte    = 8'h00;
   logic       req_ack_bit    = 1'b0;
   logic       req_sda_in     = 1'b1;
   logic       csr_valid      = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_data       = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic       rsp_scl_out;
   logic       rsp_sda_out;
   logic       rsp_busy_res;
   logic       rsp_done_res;
   logic [7:0] rsp_rx_byte;
   logic       rsp_ack_failed;

   bit calm      = 1'b0;   // no idling on either side while set
   int nack_bias = 50;     // percent of receive ack polls that see SDA high
   int live_items = 0;
   int settings   = 1;
   int cycles     = 0;

   bit_engine_scoreboard sb = new();

   i2c_master_bit_engine_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_tx_byte    (req_tx_byte),
      .req_ack_bit    (req_ack_bit),
      .req_sda_in     (req_sda_in),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_scl_out    (rsp_scl_out),
      .rsp_sda_out    (rsp_sda_out),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_rx_byte    (rsp_rx_byte),
      .rsp_ack_failed (rsp_ack_failed)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < 16);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response({rsp_scl_out, rsp_sda_out, rsp_busy_res, rsp_done_res,
                            rsp_rx_byte, rsp_ack_failed});
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Present one item and hold it until the transfer happens.
   task automatic send_item(logic [2:0] kind, logic [7:0] tx, logic ackb, logic sdai);
      while (!calm && $urandom_range(0, 99) < 16) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_type    <= kind;
      req_tx_byte <= tx;
      req_ack_bit <= ackb;
      req_sda_in  <= sdai;
      do @(posedge clock); while (req_stall);
      if (sb.note_request(kind, tx, ackb, sdai)) live_items++;
   endtask

   function automatic logic [7:0] pick_tx();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [2:0] pick_cmd();
      return 3'($urandom_range(REQ_START, REQ_RACK));
   endfunction

   function automatic logic pick_sda();
      if (sb.seq_cmd == REQ_RACK) return $urandom_range(0, 99) < nack_bias;
      return 1'($urandom_range(0, 1));
   endfunction

   task automatic send_tick(logic sdai);
      logic [2:0] kind;
      kind = ($urandom_range(0, 9) == 0) ? REQ_UNUSED : REQ_TICK;
      send_item(kind, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), sdai);
   endtask

   task automatic send_command();
      send_item(pick_cmd(), pick_tx(), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
   endtask

   // Tick until the running command ends, with an occasional ignored command.
   task automatic finish_command();
      while (sb.busy()) begin
         if ($urandom_range(0, 99) < 5) send_command();
         else send_tick(pick_sda());
      end
   endtask

   task automatic random_round();
      int pick;
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
         0:       nack_bias = 0;
         1:       nack_bias = 25;
         2:       nack_bias = 60;
         default: nack_bias = 100;
      endcase
      if (pick < 10) begin
         repeat ($urandom_range(1, 3)) send_tick(pick_sda());
      end else if (pick < 20) begin
         // push a command at a running sequence, where it is ignored, then another
         send_command();
         repeat ($urandom_range(0, 4)) send_tick(pick_sda());
         send_command();
      end else begin
         finish_command();
         send_command();
         finish_command();
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_ack_timeout(logic [7:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid    <= 1'b0;
      sb.ack_limit = value;
      settings++;
   endtask

   initial begin
      int         target;
      logic [7:0] limit;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // idle ticks, including the unused code
      send_item(REQ_TICK, 8'h00, 1'b0, 1'b0);
      send_item(REQ_UNUSED, 8'hFF, 1'b1, 1'b1);
      // start, with a stop pushed at it while busy
      send_item(REQ_START, 8'hFF, 1'b1, 1'b1);
      send_item(REQ_TICK, 8'h00, 1'b0, 1'b1);
      send_item(REQ_STOP, 8'h00, 1'b0, 1'b0);
      repeat (3) send_item(REQ_TICK, 8'h00, 1'b0, 1'b0);
      // send nack level
      send_item(REQ_SACK, 8'h00, 1'b1, 1'b0);
      repeat (3) send_item(REQ_UNUSED, 8'h00, 1'b0, 1'b0);
      // receive ack: one failed poll, then ack
      send_item(REQ_RACK, 8'h00, 1'b0, 1'b1);
      send_item(REQ_TICK, 8'h00, 1'b0, 1'b1);
      send_item(REQ_TICK, 8'h00, 1'b0, 1'b1);
      send_item(REQ_TICK, 8'h00, 1'b0, 1'b0);
      send_item(REQ_TICK, 8'h00, 1'b0, 1'b0);
      send_item(REQ_STOP, 8'hFF, 1'b1, 1'b1);
      repeat (3) send_item(REQ_TICK, 8'hFF, 1'b1, 1'b1);
      // no polls allowed: first failed poll turns into stop and nack
      write_ack_timeout(8'd0);
      send_item(REQ_RACK, 8'h00, 1'b0, 1'b1);
      send_item(REQ_TICK, 8'h00, 1'b0, 1'b1);
      send_item(REQ_TICK, 8'h00, 1'b0, 1'b1);
      repeat (3) send_item(REQ_TICK, 8'h00, 1'b0, 1'b1);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       limit = 8'd255;
            1:       limit = 8'd1;
            2:       limit = 8'd0;
            3:       limit = 8'($urandom_range(2, 9));
            4:       limit = 8'd3;
            default: limit = 8'($urandom_range(0, 255));
         endcase
         write_ack_timeout(limit);
         if (p == 2) calm <= 1'b1;
         target = live_items + RANDOM_ITEMS / PHASES;
         while (live_items < target) random_round();
         if (p == 2) calm <= 1'b0;
      end

      drain();
      repeat (10) @(posedge clock);
      $display("Checked %0d results; %0d commands completed, %0d of them by ack timeout.",
               sb.results, sb.completed, sb.timeouts);
      $display("Sent %0d effective items under %0d ack timeout settings.",
               live_items, settings);
      if (sb.errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
